// ----- design/bol_pkg.sv -----
// ----------------------------------------------------------------------------
// bol_pkg
// Shared types and codes for the bounded ordered list: transfer payloads,
// action and status codes, and the per-cell operation code.
// ----------------------------------------------------------------------------
package bol_pkg;

    localparam int BOL_CAPACITY = 64;
    localparam int VALUE_W      = 32;
    localparam int ACTION_W     = 3;
    localparam int POS_W        = 6;
    localparam int STATUS_W     = 2;
    localparam int COUNT_OUT_W  = 7;

    localparam logic [ACTION_W-1:0] ACT_APPEND      = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PREPEND     = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_REMOVE_HEAD = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_REMOVE_TAIL = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_REMOVE_AT   = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_CLEAR       = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_INDEX = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0]       action;
        logic signed [VALUE_W-1:0] item_value;
        logic [POS_W-1:0]          position;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [COUNT_OUT_W-1:0] entry_count;
    } t_out_item;

    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_LOAD       = 2'd1,
        CELL_TAKE_LEFT  = 2'd2,
        CELL_TAKE_RIGHT = 2'd3
    } t_cell_op;

endpackage

// ----- design/bol_cell.sv -----
// ----------------------------------------------------------------------------
// bol_cell
// One entry of the list. Loads the new value at its own position, takes its
// left neighbor on an insert at the head, or its right neighbor on a removal
// at or below its position.
// ----------------------------------------------------------------------------
module bol_cell #(
    parameter int IDX   = 0,
    parameter int SEL_W = 7
) (
    input  logic                               i_clk,
    input  bol_pkg::t_cell_op                  i_op,
    input  logic [SEL_W-1:0]                   i_sel,
    input  logic signed [bol_pkg::VALUE_W-1:0] i_value,
    input  logic signed [bol_pkg::VALUE_W-1:0] i_from_left,
    input  logic signed [bol_pkg::VALUE_W-1:0] i_from_right,
    output logic signed [bol_pkg::VALUE_W-1:0] o_entry
);
    import bol_pkg::*;

    localparam logic [SEL_W-1:0] MY_IDX = SEL_W'(IDX);

    logic signed [VALUE_W-1:0] r_entry;
    logic signed [VALUE_W-1:0] n_entry;

    always_comb begin
        n_entry = r_entry;
        unique case (i_op)
            CELL_HOLD: begin
                n_entry = r_entry;
            end
            CELL_LOAD: begin
                if (i_sel == MY_IDX) begin
                    n_entry = i_value;
                end
            end
            CELL_TAKE_LEFT: begin
                n_entry = i_from_left;
            end
            CELL_TAKE_RIGHT: begin
                if (MY_IDX >= i_sel) begin
                    n_entry = i_from_right;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// ----- design/bounded_ordered_list_top.sv -----
// ----------------------------------------------------------------------------
// bounded_ordered_list_top
// Ordered list of up to CAPACITY signed 32-bit values held in a row of cells,
// with append, prepend, head/tail removal, removal by position and clear.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one action per
//   transfer. Output channel (o_out_valid / i_out_ready / o_out_data) returns
//   exactly one status and the entry count after the action, in order.
//   The result is registered and presented in the cycle after the input transfer.
//   Throughput: one item per cycle while the receiver takes each result. Every
//   action completes at once because all cells shift toward or away from the head in parallel.
//   Refused actions (full, empty, no such index) leave the list unchanged.
//   Reset empties the list; entry contents are undefined until written.
//   While the receiver stalls, the result register holds and o_in_ready
//   drops until the pending result is transferred; a new item is accepted
//   in the same cycle the pending result leaves.
//   entry_count shows the count modulo 128; positions reach 63 at most.
// ----------------------------------------------------------------------------
module bounded_ordered_list_top #(
    parameter int CAPACITY = bol_pkg::BOL_CAPACITY
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bol_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bol_pkg::t_out_item o_out_data
);
    import bol_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    t_out_item        r_out_data;

    logic             w_fire;
    logic             w_full;
    logic             w_empty;
    logic             w_pos_ok;
    logic [CMP_W-1:0] w_pos_ext;
    logic [STATUS_W-1:0] w_status;
    t_cell_op         w_op;
    logic [CNT_W-1:0] w_sel;

    logic signed [VALUE_W-1:0] w_entry [CAPACITY];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_fire     = i_in_valid && o_in_ready;
    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_empty    = (r_count == '0);
    assign w_pos_ext  = CMP_W'(i_in_data.position);
    assign w_pos_ok   = (w_pos_ext < CMP_W'(r_count));

    always_comb begin
        n_count  = r_count;
        w_status = ST_OK;
        w_op     = CELL_HOLD;
        w_sel    = '0;
        unique case (i_in_data.action)
            ACT_APPEND: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_op    = CELL_LOAD;
                    w_sel   = r_count;
                    n_count = r_count + 1'b1;
                end
            end
            ACT_PREPEND: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_op    = CELL_TAKE_LEFT;
                    n_count = r_count + 1'b1;
                end
            end
            ACT_REMOVE_HEAD: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_op    = CELL_TAKE_RIGHT;
                    w_sel   = '0;
                    n_count = r_count - 1'b1;
                end
            end
            ACT_REMOVE_TAIL: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_op    = CELL_TAKE_RIGHT;
                    w_sel   = r_count - 1'b1;
                    n_count = r_count - 1'b1;
                end
            end
            ACT_REMOVE_AT: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else if (!w_pos_ok) begin
                    w_status = ST_NO_INDEX;
                end else begin
                    w_op    = CELL_TAKE_RIGHT;
                    w_sel   = CNT_W'(w_pos_ext);
                    n_count = r_count - 1'b1;
                end
            end
            ACT_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
        if (!w_fire) begin
            w_op    = CELL_HOLD;
            n_count = r_count;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [VALUE_W-1:0] w_left;
        logic signed [VALUE_W-1:0] w_right;
        if (g == 0) begin : g_head
            assign w_left = i_in_data.item_value;
        end else begin : g_mid_l
            assign w_left = w_entry[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_entry[g+1];
        end
        bol_cell #(
            .IDX   (g),
            .SEL_W (CNT_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_op         (w_op),
            .i_sel        (w_sel),
            .i_value      (i_in_data.item_value),
            .i_from_left  (w_left),
            .i_from_right (w_right),
            .o_entry      (w_entry[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_data.status      <= w_status;
            r_out_data.entry_count <= COUNT_OUT_W'(n_count);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid && (r_out_data.status == $past(w_status)))
        else $error("result not presented after input transfer");

    a_refused_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && (w_status != ST_OK) |=> r_count == $past(r_count))
        else $error("refused action changed the count");

    a_count_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_data.entry_count == COUNT_OUT_W'(r_count))
        else $error("reported count differs from held count");

endmodule

// ----- tb/list_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// list_checker
// Watches both transfer channels of the bounded ordered list. Each accepted
// action is applied to a queue that mirrors the list, which gives the status
// and entry count that the block must return. Returned results are compared
// in order against those expected results; mismatches and stray results are counted.
// ----------------------------------------------------------------------------
module list_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  bol_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  bol_pkg::t_out_item i_out_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_list_len,
    output int                 o_checked,
    output int                 o_refused,
    output int                 o_peak_len
);
    import bol_pkg::*;

    localparam int PRINT_CAP = 30;

    logic signed [VALUE_W-1:0] held_values [$];
    t_out_item                 awaited_results [$];

    task automatic report_mismatch(input string what, input int got, input int want);
        o_fail_count++;
        if (o_fail_count <= PRINT_CAP) begin
            $display("%0t ns: %s: got %0d, want %0d", $realtime, what, got, want);
        end
    endtask

    function automatic t_out_item apply_action(input t_in_item item);
        t_out_item res;
        res.status = ST_OK;
        case (item.action)
            ACT_APPEND: begin
                if (held_values.size() >= BOL_CAPACITY) res.status = ST_FULL;
                else held_values.push_back(item.item_value);
            end
            ACT_PREPEND: begin
                if (held_values.size() >= BOL_CAPACITY) res.status = ST_FULL;
                else held_values.push_front(item.item_value);
            end
            ACT_REMOVE_HEAD: begin
                if (held_values.size() == 0) res.status = ST_EMPTY;
                else void'(held_values.pop_front());
            end
            ACT_REMOVE_TAIL: begin
                if (held_values.size() == 0) res.status = ST_EMPTY;
                else void'(held_values.pop_back());
            end
            ACT_REMOVE_AT: begin
                if (held_values.size() == 0) res.status = ST_EMPTY;
                else if (int'(item.position) >= held_values.size()) res.status = ST_NO_INDEX;
                else held_values.delete(int'(item.position));
            end
            ACT_CLEAR: begin
                held_values.delete();
            end
            default: begin
            end
        endcase
        res.entry_count = COUNT_OUT_W'(held_values.size());
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            held_values.delete();
            awaited_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                o_checked++;
                if (awaited_results.size() == 0) begin
                    report_mismatch("result with nothing pending", int'(i_out_data.status), -1);
                end else begin
                    want = awaited_results.pop_front();
                    if (i_out_data.status !== want.status) begin
                        report_mismatch("status", int'(i_out_data.status), int'(want.status));
                    end
                    if (i_out_data.entry_count !== want.entry_count) begin
                        report_mismatch("entry_count", int'(i_out_data.entry_count),
                                        int'(want.entry_count));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                want = apply_action(i_in_data);
                awaited_results.push_back(want);
                if (want.status != ST_OK) o_refused++;
                if (held_values.size() > o_peak_len) o_peak_len = held_values.size();
            end
        end
        o_pending  <= awaited_results.size();
        o_list_len <= held_values.size();
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the bounded ordered list. A short directed run
// hits empty, value-extreme and index edge cases, then three random phases of
// grow, shrink and mixed action blocks run under varying sender and
// receiver idling, each with one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
    import bol_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_7 = 3'd7;

    localparam int ITEMS_PER_PHASE = 600;
    localparam int BLOCK_LEN       = 90;
    localparam int LONG_STALL      = 80;
    localparam int SETTLE_CYCLES   = 8;
    localparam int CYCLE_LIMIT     = 200000;

    typedef enum int {
        MIX_GROW,
        MIX_SHRINK,
        MIX_ANY
    } t_mix;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      out_ready = 1'b0;
    t_in_item  in_data   = '0;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_data;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int stall_ask   = 0;
    int stall_seen  = 0;
    int stall_left  = 0;
    int cycles      = 0;

    int fail_count;
    int pending;
    int list_len;
    int checked;
    int refused;
    int peak_len;

    bounded_ordered_list_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    list_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_list_len   (list_len),
        .o_checked    (checked),
        .o_refused    (refused),
        .o_peak_len   (peak_len)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (stall_ask != stall_seen) begin
            stall_seen <= stall_ask;
            stall_left <= LONG_STALL;
            out_ready  <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    function automatic t_in_item make_item(input logic [ACTION_W-1:0] action,
                                           input logic [VALUE_W-1:0] value,
                                           input logic [POS_W-1:0] position);
        t_in_item item;
        item.action     = action;
        item.item_value = value;
        item.position   = position;
        return item;
    endfunction

    function automatic t_in_item pick_item(input t_mix mix, input int len);
        t_in_item item;
        int       roll;
        int       last;
        last            = (len > 0) ? len - 1 : 0;
        item.item_value = $urandom;
        item.position   = POS_W'($urandom_range(0, 63));
        roll            = $urandom_range(0, 99);
        if (mix == MIX_GROW && roll < 90) begin
            item.action = (roll % 2 == 0) ? ACT_APPEND : ACT_PREPEND;
        end else if (mix == MIX_SHRINK && roll < 90) begin
            case (roll % 3)
                0:       item.action = ACT_REMOVE_HEAD;
                1:       item.action = ACT_REMOVE_TAIL;
                default: item.action = ACT_REMOVE_AT;
            endcase
        end else begin
            item.action = ACTION_W'($urandom_range(0, 7));
        end
        if (item.action == ACT_REMOVE_AT) begin
            case ($urandom_range(0, 3))
                0:       item.position = '0;
                1:       item.position = POS_W'(last);
                2:       item.position = POS_W'($urandom_range(0, last));
                default: item.position = POS_W'($urandom_range(0, 63));
            endcase
        end
        return item;
    endfunction

    // call at a rising edge; returns at the edge of the transfer
    task automatic send_item(input t_in_item item);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(negedge clk);
        while (!in_ready) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        @(posedge clk);
    endtask

    initial begin : stimulus
        t_mix mix;
        int   phase;
        int   k;
        mix = MIX_ANY;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // refusals on an empty list, clear on empty, spare codes
        send_item(make_item(ACT_REMOVE_HEAD, 32'h0000_0000, 6'd0));
        send_item(make_item(ACT_REMOVE_TAIL, 32'hFFFF_FFFF, 6'd63));
        send_item(make_item(ACT_REMOVE_AT,   32'h0000_0000, 6'd0));
        send_item(make_item(ACT_CLEAR,       32'h1234_5678, 6'd5));
        send_item(make_item(ACT_SPARE_6,     32'h5555_5555, 6'h2A));
        send_item(make_item(ACT_SPARE_7,     32'hAAAA_AAAA, 6'h15));
        // value extremes at both ends
        send_item(make_item(ACT_APPEND,      32'h7FFF_FFFF, 6'd63));
        send_item(make_item(ACT_APPEND,      32'h8000_0000, 6'd0));
        send_item(make_item(ACT_PREPEND,     32'h0000_0000, 6'd1));
        send_item(make_item(ACT_PREPEND,     32'hFFFF_FFFF, 6'd2));
        // positions past the end, then the last entry by position
        send_item(make_item(ACT_REMOVE_AT,   32'h0000_0000, 6'd63));
        send_item(make_item(ACT_REMOVE_AT,   32'h0000_0000, 6'd4));
        send_item(make_item(ACT_REMOVE_AT,   32'h0000_0000, 6'd3));
        send_item(make_item(ACT_REMOVE_AT,   32'hFFFF_FFFF, 6'd1));
        send_item(make_item(ACT_SPARE_6,     32'h0F0F_0F0F, 6'd0));
        send_item(make_item(ACT_APPEND,      32'h0000_1234, 6'd33));
        send_item(make_item(ACT_REMOVE_HEAD, 32'hFFFF_FFFF, 6'd63));
        send_item(make_item(ACT_REMOVE_TAIL, 32'h7FFF_FFFF, 6'd0));
        send_item(make_item(ACT_REMOVE_AT,   32'h0000_0000, 6'd0));
        send_item(make_item(ACT_APPEND,      32'h0000_002A, 6'd0));
        send_item(make_item(ACT_PREPEND,     32'h0000_0007, 6'd0));
        send_item(make_item(ACT_CLEAR,       32'h0000_0000, 6'd63));
        wait_drained();

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 38;
                    rx_idle_pct <= 51;
                end
                1: begin
                    tx_idle_pct = 51;
                    rx_idle_pct <= 38;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct <= 0;
                end
            endcase
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (k % BLOCK_LEN == 0) mix = t_mix'($urandom_range(0, 2));
                if (k == ITEMS_PER_PHASE / 4) stall_ask <= stall_ask + 1;
                send_item(pick_item(mix, list_len));
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d results, %0d refused actions, list depth peaked at %0d of %0d",
                 checked, refused, peak_len, BOL_CAPACITY);
        $display("idling mixes 38/51, 51/38 and none, each with one long receiver hold-off");
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
